[rtl/bitmap_segment_allocator_top_macros.svh]
// Assertion macros shared by the segment allocator RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef BITMAP_SEGMENT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SEGMENT_ALLOCATOR_TOP_MACROS_SVH

// Same-cycle implication.
`define BSA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment allocator assertion failed");

// Next-cycle implication.
`define BSA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment allocator assertion failed");

`endif

[rtl/bsa_pkg.sv]
// Shared types and constants of the bitmap segment allocator.
// Used by bsa_ctrl, bsa_datapath and bitmap_segment_allocator_top; no dependencies.
package bsa_pkg;

  // Bitmap rows: segments held per memory word.
  localparam int unsigned SEG_PER_ROW   = 32;
  localparam int unsigned SEG_PER_ROW_W = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // Action codes.
  localparam logic [2:0] ACT_ALLOC   = 3'd0;
  localparam logic [2:0] ACT_FREE    = 3'd1;
  localparam logic [2:0] ACT_ACQUIRE = 3'd2;
  localparam logic [2:0] ACT_UNLOCK  = 3'd3;
  localparam logic [2:0] ACT_QUERY   = 3'd4;

  // Status codes.
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_NOT_ALLOC = 3'd2;
  localparam logic [2:0] ST_LOCKED    = 3'd3;
  localparam logic [2:0] ST_RANGE     = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_SEG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GROW     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLICY   = 2'd2;

  // Growth policies.
  localparam logic [1:0] POL_EXPAND = 2'd1;
  localparam logic [1:0] POL_AUTO   = 2'd2;

  // Register reset values.
  localparam logic [6:0] INIT_SEG_RST  = 7'd16;
  localparam logic [6:0] GROW_STEP_RST = 7'd8;
  localparam logic [1:0] POLICY_RST    = 2'd0;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] segment_index;
  } bsa_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [5:0] granted_segment;
    logic [6:0] active_count;
    logic [6:0] free_segments;
    logic [6:0] locked_segments;
  } bsa_rsp_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;   // accept the request and issue the first row read
    logic exec;   // evaluate the row read last cycle
  } bsa_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic scan_more;  // alloc found no free segment in this row
  } bsa_sts_t;

endpackage

[rtl/bsa_ctrl.sv]
// Controller state machine of the segment allocator.
// Depends on bsa_pkg and the assertion macro header.
`include "bitmap_segment_allocator_top_macros.svh"

module bsa_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  bsa_pkg::bsa_sts_t sts,
  output logic              busy,
  output bsa_pkg::bsa_cmd_t cmd
);
  import bsa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  assign busy     = (state == S_EXEC);
  assign cmd.load = (state == S_IDLE) && start;
  assign cmd.exec = (state == S_EXEC);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // An alloc that misses in a row stays here for the next row.
        if (!sts.scan_more) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `BSA_ASSERT_NXT(a_load_then_busy, cmd.load, busy)
  `BSA_ASSERT_IMP(a_no_load_when_busy, busy, !cmd.load)
  `BSA_ASSERT_IMP(a_state_onehot, 1'b1, $onehot(state))

endmodule

[rtl/bsa_datapath.sv]
// Datapath of the segment allocator: registers, counters and the bitmap memory.
// Depends on bsa_pkg and the assertion macro header.
`include "bitmap_segment_allocator_top_macros.svh"

module bsa_datapath #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  bsa_pkg::bsa_req_t                  req,
  input  bsa_pkg::bsa_cmd_t                  cmd,
  output bsa_pkg::bsa_sts_t                  sts,
  output logic                               done,
  output bsa_pkg::bsa_rsp_t                  rsp
);
  import bsa_pkg::*;

  localparam int unsigned NROWS = (MAX_SEGMENTS + SEG_PER_ROW - 1) / SEG_PER_ROW;
  localparam int unsigned ROW_W = (NROWS > 1) ? $clog2(NROWS) : 1;
  localparam int unsigned IDX_W = ROW_W + SEG_PER_ROW_W;
  localparam int unsigned CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned SUM_W = ((CNT_W > CFG_DATA_W) ? CNT_W : CFG_DATA_W) + 1;
  localparam int unsigned CMP_W = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

  function automatic logic [CNT_W-1:0] clamp_init(input logic [CFG_DATA_W-1:0] v);
    logic [SUM_W-1:0] w;
    logic [CNT_W-1:0] r;
    w = SUM_W'(v);
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (w > SUM_W'(MAX_SEGMENTS)) begin
      r = CNT_W'(MAX_SEGMENTS);
    end else begin
      r = CNT_W'(w);
    end
    return r;
  endfunction

  function automatic logic [6:0] out7(input logic [CNT_W-1:0] c);
    logic [SUM_W-1:0] w;
    w = SUM_W'(c);
    return w[6:0];
  endfunction

  // Configuration registers.
  logic [CFG_DATA_W-1:0] grow_step;
  logic [1:0]            policy;

  // Pool counters.
  logic [CNT_W-1:0] act_cnt, act_next;
  logic [CNT_W-1:0] free_cnt, free_next;
  logic [CNT_W-1:0] lock_cnt, lock_next;

  // Bitmap memory: one row of used bits and one of lock bits per address.
  // A row whose valid flag is clear reads as all zero.
  logic [SEG_PER_ROW-1:0] used_mem [NROWS];
  logic [SEG_PER_ROW-1:0] lock_mem [NROWS];
  logic [NROWS-1:0]       row_valid;
  logic [SEG_PER_ROW-1:0] rd_used, rd_lock;
  logic                   rd_ok;

  bsa_req_t               req_q;
  logic [ROW_W-1:0]       row;
  logic [ROW_W-1:0]       rd_addr;
  logic [ROW_W-1:0]       seg_row;

  logic                   init_wr;
  logic                   grow_now;
  logic [SUM_W-1:0]       grow_sum;
  logic [CNT_W-1:0]       grown;

  logic [SEG_PER_ROW-1:0] cur_used, cur_lock;
  logic [SEG_PER_ROW-1:0] row_mask, avail;
  logic [SEG_PER_ROW_W-1:0] bitsel, pick;
  logic                   found;
  logic                   in_range;
  logic [CMP_W-1:0]       act_e, base_e, rem_e;
  logic [IDX_W-1:0]       grant_idx;

  logic                   wr_en;
  logic [SEG_PER_ROW-1:0] wr_used, wr_lock;
  logic                   scan_more;
  logic [2:0]             status;
  logic [5:0]             granted;

  logic                   counts_ok;
  logic                   active_ok;

  assign init_wr = cfg_we && (cfg_index == CFG_INIT_SEG);

  // Growth happens when the request is taken, so the scan sees the new range.
  assign grow_now = (req.action == ACT_ALLOC) && (free_cnt == '0) &&
                    ((policy == POL_EXPAND) || (policy == POL_AUTO));
  assign grow_sum = SUM_W'(act_cnt) + SUM_W'(grow_step);
  assign grown    = (grow_sum > SUM_W'(MAX_SEGMENTS)) ? CNT_W'(MAX_SEGMENTS)
                                                       : CNT_W'(grow_sum);

  assign seg_row = ROW_W'(req.segment_index >> SEG_PER_ROW_W);
  assign rd_addr = cmd.load ? ((req.action == ACT_ALLOC) ? '0 : seg_row)
                            : row + ROW_W'(1);

  assign cur_used = rd_ok ? rd_used : '0;
  assign cur_lock = rd_ok ? rd_lock : '0;
  assign bitsel   = req_q.segment_index[SEG_PER_ROW_W-1:0];

  // Segments of this row that lie inside the active range.
  assign act_e  = CMP_W'(act_cnt);
  assign base_e = CMP_W'({row, {SEG_PER_ROW_W{1'b0}}});
  assign rem_e  = act_e - base_e;

  always_comb begin
    if (act_e >= base_e + CMP_W'(SEG_PER_ROW)) begin
      row_mask = '1;
    end else if (act_e > base_e) begin
      row_mask = (SEG_PER_ROW'(1) << rem_e[SEG_PER_ROW_W-1:0]) - SEG_PER_ROW'(1);
    end else begin
      row_mask = '0;
    end
  end

  assign avail = ~cur_used & row_mask;
  assign found = |avail;

  always_comb begin
    pick = '0;
    for (int b = SEG_PER_ROW - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pick = SEG_PER_ROW_W'(b);
      end
    end
  end

  assign grant_idx = {row, pick};
  assign in_range  = CMP_W'(req_q.segment_index) < act_e;

  always_comb begin
    act_next  = act_cnt;
    free_next = free_cnt;
    lock_next = lock_cnt;
    wr_en     = 1'b0;
    wr_used   = cur_used;
    wr_lock   = cur_lock;
    scan_more = 1'b0;
    status    = ST_OK;
    granted   = '0;
    if (init_wr) begin
      act_next  = clamp_init(cfg_data);
      free_next = clamp_init(cfg_data);
      lock_next = '0;
    end else if (cmd.load) begin
      if (grow_now) begin
        act_next  = grown;
        free_next = grown - act_cnt;
      end
    end else if (cmd.exec) begin
      case (req_q.action)
        ACT_ALLOC: begin
          if (free_cnt == '0) begin
            status = ST_FULL;
          end else if (found) begin
            wr_en         = 1'b1;
            wr_used[pick] = 1'b1;
            wr_lock[pick] = 1'b1;
            free_next     = free_cnt - CNT_W'(1);
            lock_next     = lock_cnt + CNT_W'(1);
            granted       = grant_idx[5:0];
          end else begin
            scan_more = 1'b1;
          end
        end
        ACT_FREE: begin
          if (!in_range) begin
            status = ST_RANGE;
          end else if (cur_lock[bitsel]) begin
            status = ST_LOCKED;
          end else if (!cur_used[bitsel]) begin
            status = ST_NOT_ALLOC;
          end else begin
            wr_en           = 1'b1;
            wr_used[bitsel] = 1'b0;
            free_next       = free_cnt + CNT_W'(1);
          end
        end
        ACT_ACQUIRE: begin
          if (!in_range) begin
            status = ST_RANGE;
          end else if (cur_lock[bitsel]) begin
            status = ST_LOCKED;
          end else if (!cur_used[bitsel]) begin
            status = ST_NOT_ALLOC;
          end else begin
            wr_en           = 1'b1;
            wr_lock[bitsel] = 1'b1;
            lock_next       = lock_cnt + CNT_W'(1);
          end
        end
        ACT_UNLOCK: begin
          if (!in_range) begin
            status = ST_RANGE;
          end else if (!cur_lock[bitsel]) begin
            status = ST_NOT_ALLOC;
          end else begin
            wr_en           = 1'b1;
            wr_lock[bitsel] = 1'b0;
            lock_next       = lock_cnt - CNT_W'(1);
          end
        end
        default: begin
          status = ST_OK;
        end
      endcase
    end
  end

  assign sts.scan_more = scan_more;

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      grow_step <= GROW_STEP_RST;
      policy    <= POLICY_RST;
      act_cnt   <= clamp_init(INIT_SEG_RST);
      free_cnt  <= clamp_init(INIT_SEG_RST);
      lock_cnt  <= '0;
      row_valid <= '0;
      done      <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_GROW:   grow_step <= cfg_data;
          CFG_POLICY: policy    <= cfg_data[1:0];
          default:    ;
        endcase
      end
      act_cnt  <= act_next;
      free_cnt <= free_next;
      lock_cnt <= lock_next;
      if (init_wr) begin
        row_valid <= '0;
      end else if (wr_en) begin
        row_valid[row] <= 1'b1;
      end
      done <= cmd.exec && !scan_more;
    end
  end

  // Payload registers and the bitmap memory.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_q <= req;
    end
    if (cmd.load || scan_more) begin
      row     <= rd_addr;
      rd_used <= used_mem[rd_addr];
      rd_lock <= lock_mem[rd_addr];
      rd_ok   <= row_valid[rd_addr];
    end
    if (wr_en) begin
      used_mem[row] <= wr_used;
      lock_mem[row] <= wr_lock;
    end
    if (cmd.exec && !scan_more) begin
      rsp.status          <= status;
      rsp.granted_segment <= granted;
      rsp.active_count    <= out7(act_next);
      rsp.free_segments   <= out7(free_next);
      rsp.locked_segments <= out7(lock_next);
    end
  end

  // Every locked segment is used, so locked plus free never exceeds active.
  assign counts_ok = ({1'b0, lock_cnt} + {1'b0, free_cnt}) <= {1'b0, act_cnt};
  assign active_ok = (act_cnt != '0) && (act_cnt <= CNT_W'(MAX_SEGMENTS));

  `BSA_ASSERT_IMP(a_counts_consistent, 1'b1, counts_ok)
  `BSA_ASSERT_IMP(a_active_bounded, 1'b1, active_ok)
  `BSA_ASSERT_IMP(a_done_after_exec, done, $past(cmd.exec))

endmodule

[rtl/bitmap_segment_allocator_top.sv]
// Top level of the bitmap segment allocator.
// Depends on bsa_pkg, bsa_ctrl and bsa_datapath.
//
//   Channel   Handshake         Payload
//   request   start / busy      req  (action, segment_index)
//   result    done strobe       rsp  (status, granted_segment, counts)
//   config    cfg_we            cfg_index, cfg_data
//
// A request is taken when start is high and busy is low; its result is shown
// for one cycle on done once the last row is evaluated, and a new request can
// be taken in that same cycle. Free, acquire, unlock and query evaluate one
// bitmap row. Alloc scans the 32-segment rows one at a time, reading each
// through the single read port of the bitmap memory. Reset needs no clearing
// pass: per-row valid flags clear at once. The result side cannot stall.
module bitmap_segment_allocator_top #(
  parameter int unsigned MAX_SEGMENTS = 64
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  bsa_pkg::bsa_req_t              req,
  output logic                           done,
  output bsa_pkg::bsa_rsp_t              rsp,
  input  logic                           cfg_we,
  input  logic [bsa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bsa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bsa_pkg::*;

  bsa_cmd_t cmd;
  bsa_sts_t sts;

  bsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  bsa_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .rsp       (rsp)
  );

endmodule
